// ----- rtl/itew_pkg.sv -----
// Shared types and word codes for the integer-to-English-words block.
package itew_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] itew_digits_t;
  typedef logic [4:0]                          itew_word_t;
  typedef logic [30:0]                         itew_number_t;

  localparam itew_word_t W_ZERO      = 5'd0;
  localparam itew_word_t W_TEN       = 5'd10;
  localparam itew_word_t W_TENS_BASE = 5'd18;
  localparam itew_word_t W_HUNDRED   = 5'd28;
  localparam itew_word_t W_THOUSAND  = 5'd29;
  localparam itew_word_t W_MILLION   = 5'd30;
  localparam itew_word_t W_BILLION   = 5'd31;

endpackage

// ----- rtl/itew_if.sv -----
// Valid/ready channel interfaces: number input, decimal digits, word output.
interface itew_in_if;
  logic                   valid;
  logic                   ready;
  itew_pkg::itew_number_t number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface itew_dig_if;
  logic                   valid;
  logic                   ready;
  itew_pkg::itew_digits_t digits;

  modport source (output valid, output digits, input ready);
  modport sink   (input valid, input digits, output ready);
endinterface

interface itew_out_if;
  logic                 valid;
  logic                 ready;
  itew_pkg::itew_word_t word_code;
  logic                 last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

// ----- rtl/itew_front.sv -----
// Front end: accepts a number and converts it to ten BCD digits, two bits per cycle.
module itew_front (
  input  logic      clk,
  input  logic      rst_n,
  itew_in_if.sink   in_ch,
  itew_dig_if.source dig_ch
);
  import itew_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_HOLD} state_t;

  localparam logic [3:0] LAST_ITER = 4'd13;

  state_t       state_r;
  logic [3:0]   cnt_r;
  logic [27:0]  bin_r;
  itew_digits_t bcd_r;
  itew_digits_t bcd_nxt;
  logic         accept;

  function automatic itew_digits_t dd_step(input itew_digits_t d, input logic b);
    itew_digits_t adj;
    logic [NUM_DIGITS*DIGIT_W-1:0] flat;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
    end
    flat = adj;
    return {flat[NUM_DIGITS*DIGIT_W-2:0], b};
  endfunction

  assign in_ch.ready   = (state_r == F_IDLE) || (state_r == F_HOLD && dig_ch.ready);
  assign accept        = in_ch.valid && in_ch.ready;
  assign dig_ch.valid  = (state_r == F_HOLD);
  assign dig_ch.digits = bcd_r;
  assign bcd_nxt       = dd_step(dd_step(bcd_r, bin_r[27]), bin_r[26]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_CONV;
            cnt_r   <= '0;
          end
        end
        F_CONV: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_ITER) begin
            state_r <= F_HOLD;
          end
        end
        F_HOLD: begin
          if (accept) begin
            state_r <= F_CONV;
            cnt_r   <= '0;
          end else if (dig_ch.ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
    // load top three bits directly: no digit can reach five before they shift in
    if (accept) begin
      bin_r <= in_ch.number[27:0];
      bcd_r <= {{(NUM_DIGITS*DIGIT_W-3){1'b0}}, in_ch.number[30:28]};
    end else if (state_r == F_CONV) begin
      bin_r <= {bin_r[25:0], 2'b00};
      bcd_r <= bcd_nxt;
    end
  end

endmodule

// ----- rtl/itew_fifo.sv -----
// Short queue of digit transactions between front and back end.
module itew_fifo #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  itew_dig_if.sink   wr_ch,
  itew_dig_if.source rd_ch
);
  import itew_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  itew_digits_t   mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic           pop;

  assign wr_ch.ready  = (cnt_r != CW'(DEPTH));
  assign rd_ch.valid  = (cnt_r != '0);
  assign rd_ch.digits = mem_r[rd_ptr_r];
  assign push         = wr_ch.valid && wr_ch.ready;
  assign pop          = rd_ch.valid && rd_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ch.digits;
    end
  end

endmodule

// ----- rtl/itew_back.sv -----
// Back end: expands BCD digits into word slots and emits one word code per cycle while out_ch is ready.
module itew_back (
  input  logic       clk,
  input  logic       rst_n,
  itew_dig_if.sink   dig_ch,
  itew_out_if.source out_ch
);
  import itew_pkg::*;

  localparam int SLOTS     = 20;
  localparam int GRP_SLOTS = 5;
  localparam int IW        = $clog2(SLOTS);

  logic [SLOTS-1:0]   vld_r;
  itew_word_t         code_r [SLOTS];
  logic [SLOTS-1:0]   vld_nxt;
  itew_word_t         code_nxt [SLOTS];
  logic               out_vld_r;
  itew_word_t         out_code_r;
  logic               out_last_r;
  logic [IW-1:0]      idx;
  logic               is_last;
  logic               adv;
  logic               load;
  logic [SLOTS-1:0]   vld_left;

  always_comb begin
    logic [3:0] h, t, u;
    logic       nz;
    int         b;
    vld_nxt = '0;
    for (int g = 0; g < 4; g++) begin
      b = g * GRP_SLOTS;
      if (g == 0) begin
        h = 4'd0;
        t = 4'd0;
        u = dig_ch.digits[9];
      end else begin
        h = dig_ch.digits[9 - 3*g + 2];
        t = dig_ch.digits[9 - 3*g + 1];
        u = dig_ch.digits[9 - 3*g];
      end
      nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
      code_nxt[b]     = {1'b0, h};
      vld_nxt[b]      = (h != 4'd0);
      code_nxt[b + 1] = W_HUNDRED;
      vld_nxt[b + 1]  = (h != 4'd0);
      if (t == 4'd1) begin
        code_nxt[b + 2] = W_TEN + {1'b0, u};
        vld_nxt[b + 2]  = 1'b1;
      end else if (t == 4'd0) begin
        code_nxt[b + 2] = {1'b0, u};
        vld_nxt[b + 2]  = (u != 4'd0);
      end else begin
        code_nxt[b + 2] = W_TENS_BASE + {1'b0, t};
        vld_nxt[b + 2]  = 1'b1;
      end
      code_nxt[b + 3] = {1'b0, u};
      vld_nxt[b + 3]  = (t >= 4'd2) && (u != 4'd0);
      unique case (g)
        0:       code_nxt[b + 4] = W_BILLION;
        1:       code_nxt[b + 4] = W_MILLION;
        default: code_nxt[b + 4] = W_THOUSAND;
      endcase
      vld_nxt[b + 4] = nz && (g != 3);
    end
    if (vld_nxt == '0) begin
      code_nxt[0] = W_ZERO;
      vld_nxt[0]  = 1'b1;
    end
  end

  always_comb begin
    logic found;
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (vld_r[i] && !found) begin
        idx   = IW'(i);
        found = 1'b1;
      end
    end
  end

  assign vld_left     = vld_r & ~(SLOTS'(1) << idx);
  assign is_last      = (vld_left == '0);
  assign adv          = (vld_r != '0) && (!out_vld_r || out_ch.ready);
  assign load         = dig_ch.valid && ((vld_r == '0) || (adv && is_last));
  assign dig_ch.ready = (vld_r == '0) || (adv && is_last);

  assign out_ch.valid     = out_vld_r;
  assign out_ch.word_code = out_code_r;
  assign out_ch.last_word = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r <= vld_nxt;
      end else if (adv) begin
        vld_r <= vld_left;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (load) begin
      code_r <= code_nxt;
    end
    if (adv) begin
      out_code_r <= code_r[idx];
      out_last_r <= is_last;
    end
  end

endmodule

// ----- rtl/integer_to_english_words.sv -----
// Top level: reads a 31-bit unsigned number out as a run of English word codes.
//
// Usage:
//   in_ch  carries one number per transaction (valid/ready).
//   out_ch carries one word code per transaction, most significant word
//          first; last_word marks the final code of each number's run.
//   A number yields 1 to 16 codes; zero yields the single code Zero.
// Timing:
//   The front end converts the number to decimal two bits per cycle, then
//   holds the digits until the queue takes them; it accepts no new number
//   while converting. Words leave through the back end's slot and output
//   registers, one word per cycle while out_ch is ready, with no gap
//   between numbers whose digits are already queued.
//   A queue of QUEUE_DEPTH digit sets lets the two ends run independently.
// Reset clears all control state; the block is ready in the cycle after reset.
// A stalled out_ch holds its word; the queue fills, then in_ch.ready drops.
module integer_to_english_words #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  itew_in_if.sink    in_ch,
  itew_out_if.source out_ch
);
  import itew_pkg::*;

  itew_dig_if q_wr_ch ();
  itew_dig_if q_rd_ch ();

  itew_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .dig_ch (q_wr_ch)
  );

  itew_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_ch (q_wr_ch),
    .rd_ch (q_rd_ch)
  );

  itew_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .dig_ch (q_rd_ch),
    .out_ch (out_ch)
  );

  a_zero_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.word_code == W_ZERO) |-> out_ch.last_word)
    else $error("Zero word not marked last");

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_reset_in_ready: assert property (@(posedge clk)
    !rst_n |=> in_ch.ready)
    else $error("input not ready after reset");

  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_ch.valid && q_rd_ch.ready |-> !out_ch.valid || out_ch.ready || !$past(rst_n)
      || out_ch.last_word)
    else $error("new digits loaded while a run is still stalled");

endmodule
